>>> rtl/pcc_pkg.sv
// Shared types, constants and microcode encodings for the clamped PID controller.
package pcc_pkg;

    // Fixed field widths
    localparam int DATA_W        = 32;
    localparam int ERR_W         = DATA_W + 1;
    localparam int ACC_W         = 48;
    localparam int TERM_W        = 62;
    localparam int CAP_SH        = 60;
    localparam int SUM_W         = 64;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int FRAC_BITS_DEF = 16;

    // Multiplier operand magnitude, consumed one digit per step from the top
    localparam int MAG_W     = 64;
    localparam int DIG_W     = 16;
    localparam int DIGITS    = MAG_W / DIG_W;
    localparam int DIG_CNT_W = $clog2(DIGITS);

    localparam int PC_W = 5;

    // Register reset values
    localparam logic signed [DATA_W-1:0] SETPOINT_RST = 32'sd0;
    localparam logic signed [DATA_W-1:0] GAIN_P_RST   = 32'sd65536;
    localparam logic signed [DATA_W-1:0] GAIN_I_RST   = 32'sd32768;
    localparam logic signed [DATA_W-1:0] GAIN_D_RST   = 32'sd0;
    localparam logic signed [DATA_W-1:0] OUT_MAX_RST  = 32'sd65536;
    localparam logic signed [DATA_W-1:0] OUT_MIN_RST  = 32'sd0;

    // Clamp status codes
    localparam logic [STATUS_W-1:0] ST_WITHIN = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HIGH   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LOW    = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT = 3'd0,
        CFG_GAIN_P   = 3'd1,
        CFG_GAIN_I   = 3'd2,
        CFG_GAIN_D   = 3'd3,
        CFG_OUT_MAX  = 3'd4,
        CFG_OUT_MIN  = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_TAKE,
        OP_MUL_LOAD,
        OP_MUL_STEP,
        OP_MUL_DONE,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_INTEG,
        OP_SUM,
        OP_OUT,
        OP_NOP
    } op_t;

    // Which product a multiply step works on (sources on load, destination on done)
    typedef enum logic [1:0] {
        PR_P,
        PR_M1,
        PR_INC,
        PR_D
    } prod_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_MUL_MORE,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t               op;
        prod_t             prod;
        cond_t             cond;
        logic [PC_W-1:0]   target;
    } uword_t;

    typedef struct packed {
        op_t   op;
        prod_t prod;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic mul_last;
        logic div_last;
        logic out_busy;
    } stat_t;

endpackage

>>> rtl/pcc_mul.sv
// Digit-serial sign-magnitude multiplier with floor shift and term saturation.
module pcc_mul #(
    parameter int FRAC_BITS = pcc_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic                             step,
    input  logic [pcc_pkg::MAG_W-1:0]        a_mag,
    input  logic                             neg,
    input  logic [pcc_pkg::DATA_W-1:0]       b_mag,
    output logic                             last,
    output logic signed [pcc_pkg::TERM_W-1:0] result
);
    import pcc_pkg::*;

    localparam int PROD_W = MAG_W + DATA_W;
    localparam int PP_W   = DIG_W + DATA_W;
    localparam logic [PROD_W-1:0] CAP = PROD_W'(1) << CAP_SH;

    logic [MAG_W-1:0]       a_reg, a_next;
    logic [DATA_W-1:0]      b_reg, b_next;
    logic                   neg_reg, neg_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [DIG_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PP_W-1:0]        pp;
    logic [PROD_W-1:0]      quo;
    logic [PROD_W-1:0]      mag_full;
    logic [CAP_SH:0]        mag_sat;
    logic [TERM_W-1:0]      term_mag;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        neg_next  = neg_reg;
        prod_next = prod_reg;
        cnt_next  = cnt_reg;
        pp        = PP_W'(a_reg[MAG_W-1 -: DIG_W]) * PP_W'(b_reg);
        if (load)
        begin
            a_next    = a_mag;
            b_next    = b_mag;
            neg_next  = neg;
            prod_next = '0;
            cnt_next  = '0;
        end
        else if (step)
        begin
            prod_next = (prod_reg << DIG_W) + PROD_W'(pp);
            a_next    = a_reg << DIG_W;
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
    end

    assign last = (cnt_reg == DIG_CNT_W'(DIGITS - 1));

    // Round the magnitude up when negative so the signed result is a floor
    always_comb
    begin
        quo      = prod_reg >> FRAC_BITS;
        mag_full = quo + PROD_W'(neg_reg & (|prod_reg[FRAC_BITS-1:0]));
        mag_sat  = (mag_full > CAP) ? CAP[CAP_SH:0] : mag_full[CAP_SH:0];
        term_mag = TERM_W'(mag_sat);
        result   = signed'(neg_reg ? (TERM_W'(0) - term_mag) : term_mag);
    end

endmodule

>>> rtl/pcc_div.sv
// Restoring divider, two quotient bits per step, for the derivative slope.
module pcc_div #(
    parameter int FRAC_BITS = pcc_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load,
    input  logic                                  step,
    input  logic [pcc_pkg::ERR_W+FRAC_BITS-1:0]   num,
    input  logic [pcc_pkg::DATA_W-1:0]            dvs,
    output logic                                  last,
    output logic [pcc_pkg::MAG_W-1:0]             quot
);
    import pcc_pkg::*;

    localparam int NUM_W     = ERR_W + FRAC_BITS;
    localparam int DIV_ITERS = (NUM_W + 1) / 2;
    localparam int DIV_W     = 2 * DIV_ITERS;
    localparam int CNT_W     = $clog2(DIV_ITERS);

    logic [DIV_W-1:0]  work_reg, work_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] r;
    logic [DIV_W-1:0]  w;

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        r         = rem_reg;
        w         = work_reg;
        trial     = '0;
        if (load)
        begin
            work_next = DIV_W'(num);
            rem_next  = '0;
            dvs_next  = dvs;
            cnt_next  = '0;
        end
        else if (step)
        begin
            // shift the dividend out the top, the quotient in at the bottom
            for (int k = 0; k < 2; k++)
            begin
                trial = {r, w[DIV_W-1]};
                w     = {w[DIV_W-2:0], 1'b0};
                if (trial >= {1'b0, dvs_reg})
                begin
                    r    = DATA_W'(trial - {1'b0, dvs_reg});
                    w[0] = 1'b1;
                end
                else
                begin
                    r = trial[DATA_W-1:0];
                end
            end
            work_next = w;
            rem_next  = r;
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign last = (cnt_reg == CNT_W'(DIV_ITERS - 1));
    assign quot = MAG_W'(work_reg);

endmodule

>>> rtl/pcc_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module pcc_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  pcc_pkg::stat_t  stat,
    output pcc_pkg::ctrl_t  ctrl
);
    import pcc_pkg::*;

    // Addresses that are jump targets
    localparam logic [PC_W-1:0] PC_TAKE   = 5'd0;
    localparam logic [PC_W-1:0] PC_STEP_P = 5'd2;
    localparam logic [PC_W-1:0] PC_STEP_I = 5'd5;
    localparam logic [PC_W-1:0] PC_STEP_N = 5'd8;
    localparam logic [PC_W-1:0] PC_DIV    = 5'd11;
    localparam logic [PC_W-1:0] PC_STEP_D = 5'd13;
    localparam logic [PC_W-1:0] PC_OUT    = 5'd17;

    logic [PC_W-1:0] pc_reg, pc_next;
    uword_t          word;
    logic            taken;

    function automatic uword_t mk(op_t op, prod_t prod, cond_t cond, logic [PC_W-1:0] tgt);
        uword_t u;
        u.op     = op;
        u.prod   = prod;
        u.cond   = cond;
        u.target = tgt;
        return u;
    endfunction

    function automatic uword_t rom(logic [PC_W-1:0] pc);
        uword_t u;
        unique case (pc)
            5'd0:    u = mk(OP_TAKE,     PR_P,   COND_NO_INPUT, PC_TAKE);
            5'd1:    u = mk(OP_MUL_LOAD, PR_P,   COND_NEVER,    PC_TAKE);
            5'd2:    u = mk(OP_MUL_STEP, PR_P,   COND_MUL_MORE, PC_STEP_P);
            5'd3:    u = mk(OP_MUL_DONE, PR_P,   COND_NEVER,    PC_TAKE);
            5'd4:    u = mk(OP_MUL_LOAD, PR_M1,  COND_NEVER,    PC_TAKE);
            5'd5:    u = mk(OP_MUL_STEP, PR_M1,  COND_MUL_MORE, PC_STEP_I);
            5'd6:    u = mk(OP_MUL_DONE, PR_M1,  COND_NEVER,    PC_TAKE);
            5'd7:    u = mk(OP_MUL_LOAD, PR_INC, COND_NEVER,    PC_TAKE);
            5'd8:    u = mk(OP_MUL_STEP, PR_INC, COND_MUL_MORE, PC_STEP_N);
            5'd9:    u = mk(OP_MUL_DONE, PR_INC, COND_NEVER,    PC_TAKE);
            5'd10:   u = mk(OP_DIV_LOAD, PR_D,   COND_NEVER,    PC_TAKE);
            5'd11:   u = mk(OP_DIV_STEP, PR_D,   COND_DIV_MORE, PC_DIV);
            5'd12:   u = mk(OP_MUL_LOAD, PR_D,   COND_NEVER,    PC_TAKE);
            5'd13:   u = mk(OP_MUL_STEP, PR_D,   COND_MUL_MORE, PC_STEP_D);
            5'd14:   u = mk(OP_MUL_DONE, PR_D,   COND_NEVER,    PC_TAKE);
            5'd15:   u = mk(OP_INTEG,    PR_P,   COND_NEVER,    PC_TAKE);
            5'd16:   u = mk(OP_SUM,      PR_P,   COND_NEVER,    PC_TAKE);
            5'd17:   u = mk(OP_OUT,      PR_P,   COND_OUT_BUSY, PC_OUT);
            default: u = mk(OP_NOP,      PR_P,   COND_ALWAYS,   PC_TAKE);
        endcase
        return u;
    endfunction

    always_comb
    begin
        word      = rom(pc_reg);
        ctrl.op   = word.op;
        ctrl.prod = word.prod;
    end

    always_comb
    begin
        unique case (word.cond)
            COND_NEVER:    taken = 1'b0;
            COND_ALWAYS:   taken = 1'b1;
            COND_NO_INPUT: taken = !stat.in_valid;
            COND_MUL_MORE: taken = !stat.mul_last;
            COND_DIV_MORE: taken = !stat.div_last;
            COND_OUT_BUSY: taken = stat.out_busy;
            default:       taken = 1'b0;
        endcase
        pc_next = taken ? word.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_TAKE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> rtl/pid_controller_clamped.sv
// Top level of the clamped PID controller: registers, datapath and stream ports.
//
// Clamped PID controller in signed fixed point (FRAC_BITS fraction bits, Q16.16 by
// default). Each input item carries a process value and a time step; the block forms
// error = setpoint - process_value and returns one item per input: the sum of the
// proportional term, the saturating 48-bit integral and the derivative term (slope
// of the error over the time step, truncated toward zero; a zero step counts as the
// smallest step), clamped first to out_max and then to out_min, with a status of
// 0 within limits, 1 clamped high, 2 clamped low. Products are floor-shifted by
// FRAC_BITS. A short microprogram drives one 16x32 multiplier digit by digit and a
// radix-4 restoring divider; four products and the divider loop dominate the time
// from acceptance of an item to the next ready. The next item is accepted while a
// finished result still waits in the output register. Configuration writes land
// immediately and must come only while the block is idle; writing the setpoint also
// clears the integral and the stored previous error. Register indexes 6 and 7 are
// ignored.
module pid_controller_clamped #(
    parameter int FRAC_BITS = pcc_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input item stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [2*pcc_pkg::DATA_W-1:0]       s_axis_tdata,  // process_value, time_step
    // result item stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [pcc_pkg::DATA_W-1:0]         m_axis_tdata,  // control_value
    output logic [pcc_pkg::STATUS_W-1:0]       m_axis_tuser,  // clamp_status
    // configuration write port
    input  logic                               cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcc_pkg::DATA_W-1:0]         cfg_data
);
    import pcc_pkg::*;

    localparam int NUM_W = ERR_W + FRAC_BITS;
    localparam int DIFF_W = ERR_W + 1;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Configuration registers
    logic signed [DATA_W-1:0] setpoint_reg, setpoint_next;
    logic signed [DATA_W-1:0] gain_p_reg, gain_p_next;
    logic signed [DATA_W-1:0] gain_i_reg, gain_i_next;
    logic signed [DATA_W-1:0] gain_d_reg, gain_d_next;
    logic signed [DATA_W-1:0] out_max_reg, out_max_next;
    logic signed [DATA_W-1:0] out_min_reg, out_min_next;

    // Controller state
    logic signed [ACC_W-1:0]  integ_reg, integ_next;
    logic signed [ERR_W-1:0]  prev_err_reg, prev_err_next;

    // Working registers of one item
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic [DATA_W-1:0]        dt_reg, dt_next;
    logic signed [TERM_W-1:0] p_reg, p_next;
    logic signed [TERM_W-1:0] m1_reg, m1_next;
    logic signed [TERM_W-1:0] inc_reg, inc_next;
    logic signed [TERM_W-1:0] d_reg, d_next;
    logic                     diff_neg_reg, diff_neg_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]        out_data_reg, out_data_next;
    logic [STATUS_W-1:0]      out_status_reg, out_status_next;

    ctrl_t ctrl;
    stat_t stat;

    // Multiplier and divider hookup
    logic                     mul_load, mul_step, mul_last, mul_neg;
    logic [MAG_W-1:0]         mul_a;
    logic [DATA_W-1:0]        mul_b;
    logic                     mul_an, mul_bn;
    logic signed [TERM_W-1:0] mul_result;
    logic                     div_load, div_step, div_last;
    logic [MAG_W-1:0]         div_quot;
    logic [NUM_W-1:0]         div_num;
    logic [DATA_W-1:0]        div_dvs;

    // Operand magnitudes
    logic [ERR_W-1:0]         err_mag;
    logic [TERM_W-1:0]        m1_mag;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_mag;
    logic signed [TERM_W:0]   acc_sum;
    logic signed [SUM_W-1:0]  max_ext, min_ext, clamp_hi;
    logic [STATUS_W-1:0]      st_hi;
    logic                     out_busy;

    function automatic logic [DATA_W-1:0] gain_mag(logic signed [DATA_W-1:0] g);
        return g[DATA_W-1] ? (DATA_W'(0) - DATA_W'(g)) : DATA_W'(g);
    endfunction

    pcc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    pcc_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (mul_load),
        .step   (mul_step),
        .a_mag  (mul_a),
        .neg    (mul_neg),
        .b_mag  (mul_b),
        .last   (mul_last),
        .result (mul_result)
    );

    pcc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (div_load),
        .step  (div_step),
        .num   (div_num),
        .dvs   (div_dvs),
        .last  (div_last),
        .quot  (div_quot)
    );

    assign s_axis_tready = (ctrl.op == OP_TAKE);
    assign out_busy      = out_valid_reg && !m_axis_tready;

    always_comb
    begin
        stat.in_valid = s_axis_tvalid;
        stat.mul_last = mul_last;
        stat.div_last = div_last;
        stat.out_busy = out_busy;
    end

    assign mul_load = (ctrl.op == OP_MUL_LOAD);
    assign mul_step = (ctrl.op == OP_MUL_STEP);
    assign div_load = (ctrl.op == OP_DIV_LOAD);
    assign div_step = (ctrl.op == OP_DIV_STEP);

    // Magnitudes and signs feeding the multiplier and divider
    always_comb
    begin
        err_mag  = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
        m1_mag   = m1_reg[TERM_W-1] ? TERM_W'(-m1_reg) : TERM_W'(m1_reg);
        diff     = DIFF_W'(err_reg) - DIFF_W'(prev_err_reg);
        diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        // error difference magnitude stays below 2^33, so the top bit of diff_mag is always clear
        div_num  = NUM_W'(diff_mag[ERR_W-1:0]) << FRAC_BITS;
        div_dvs  = (dt_reg == '0) ? DATA_W'(1) : dt_reg;

        case (ctrl.prod)
            PR_P:
            begin
                mul_a  = MAG_W'(err_mag);
                mul_an = err_reg[ERR_W-1];
                mul_b  = gain_mag(gain_p_reg);
                mul_bn = gain_p_reg[DATA_W-1];
            end
            PR_M1:
            begin
                mul_a  = MAG_W'(err_mag);
                mul_an = err_reg[ERR_W-1];
                mul_b  = gain_mag(gain_i_reg);
                mul_bn = gain_i_reg[DATA_W-1];
            end
            PR_INC:
            begin
                mul_a  = MAG_W'(m1_mag);
                mul_an = m1_reg[TERM_W-1];
                mul_b  = dt_reg;
                mul_bn = 1'b0;
            end
            default:
            begin
                mul_a  = div_quot;
                mul_an = diff_neg_reg;
                mul_b  = gain_mag(gain_d_reg);
                mul_bn = gain_d_reg[DATA_W-1];
            end
        endcase
        mul_neg = mul_an ^ mul_bn;
    end

    // Integral saturation and output clamp
    always_comb
    begin
        acc_sum  = (TERM_W+1)'(integ_reg) + (TERM_W+1)'(inc_reg);
        max_ext  = SUM_W'(out_max_reg);
        min_ext  = SUM_W'(out_min_reg);
        if (sum_reg > max_ext)
        begin
            clamp_hi = max_ext;
            st_hi    = ST_HIGH;
        end
        else
        begin
            clamp_hi = sum_reg;
            st_hi    = ST_WITHIN;
        end
    end

    // Datapath next values: one microcode operation per cycle
    always_comb
    begin
        setpoint_next   = setpoint_reg;
        gain_p_next     = gain_p_reg;
        gain_i_next     = gain_i_reg;
        gain_d_next     = gain_d_reg;
        out_max_next    = out_max_reg;
        out_min_next    = out_min_reg;
        integ_next      = integ_reg;
        prev_err_next   = prev_err_reg;
        err_next        = err_reg;
        dt_next         = dt_reg;
        p_next          = p_reg;
        m1_next         = m1_reg;
        inc_next        = inc_reg;
        d_next          = d_reg;
        diff_neg_next   = diff_neg_reg;
        sum_next        = sum_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        // drop the held result once the sink takes it
        out_valid_next  = out_valid_reg && !m_axis_tready;

        unique case (ctrl.op)
            OP_TAKE:
            begin
                if (s_axis_tvalid)
                begin
                    err_next = ERR_W'(setpoint_reg)
                             - ERR_W'(signed'(s_axis_tdata[DATA_W-1:0]));
                    dt_next  = s_axis_tdata[2*DATA_W-1:DATA_W];
                end
            end
            OP_MUL_DONE:
            begin
                case (ctrl.prod)
                    PR_P:    p_next   = mul_result;
                    PR_M1:   m1_next  = mul_result;
                    PR_INC:  inc_next = mul_result;
                    default: d_next   = mul_result;
                endcase
            end
            OP_DIV_LOAD:
            begin
                diff_neg_next = diff[DIFF_W-1];
            end
            OP_INTEG:
            begin
                if (acc_sum > (TERM_W+1)'(ACC_MAX))
                begin
                    integ_next = ACC_MAX;
                end
                else if (acc_sum < (TERM_W+1)'(ACC_MIN))
                begin
                    integ_next = ACC_MIN;
                end
                else
                begin
                    integ_next = acc_sum[ACC_W-1:0];
                end
                prev_err_next = err_reg;
            end
            OP_SUM:
            begin
                sum_next = SUM_W'(p_reg) + SUM_W'(integ_reg) + SUM_W'(d_reg);
            end
            OP_OUT:
            begin
                // hold until the output register is free, then load the result
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    if (clamp_hi < min_ext)
                    begin
                        out_data_next   = min_ext[DATA_W-1:0];
                        out_status_next = ST_LOW;
                    end
                    else
                    begin
                        out_data_next   = clamp_hi[DATA_W-1:0];
                        out_status_next = st_hi;
                    end
                end
            end
            OP_MUL_LOAD, OP_MUL_STEP, OP_DIV_STEP, OP_NOP:
            begin
            end
            default:
            begin
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SETPOINT:
                begin
                    setpoint_next = signed'(cfg_data);
                    integ_next    = '0;
                    prev_err_next = '0;
                end
                CFG_GAIN_P:  gain_p_next  = signed'(cfg_data);
                CFG_GAIN_I:  gain_i_next  = signed'(cfg_data);
                CFG_GAIN_D:  gain_d_next  = signed'(cfg_data);
                CFG_OUT_MAX: out_max_next = signed'(cfg_data);
                CFG_OUT_MIN: out_min_next = signed'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg  <= SETPOINT_RST;
            gain_p_reg    <= GAIN_P_RST;
            gain_i_reg    <= GAIN_I_RST;
            gain_d_reg    <= GAIN_D_RST;
            out_max_reg   <= OUT_MAX_RST;
            out_min_reg   <= OUT_MIN_RST;
            integ_reg     <= '0;
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            setpoint_reg  <= setpoint_next;
            gain_p_reg    <= gain_p_next;
            gain_i_reg    <= gain_i_next;
            gain_d_reg    <= gain_d_next;
            out_max_reg   <= out_max_next;
            out_min_reg   <= out_min_next;
            integ_reg     <= integ_next;
            prev_err_reg  <= prev_err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg        <= err_next;
        dt_reg         <= dt_next;
        p_reg          <= p_next;
        m1_reg         <= m1_next;
        inc_reg        <= inc_next;
        d_reg          <= d_next;
        diff_neg_reg   <= diff_neg_next;
        sum_reg        <= sum_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

>>> dv/tb_pid_controller_clamped.sv
`timescale 1ns / 100ps
// Self-checking testbench for the clamped PID controller stream block.
module tb_pid_controller_clamped;
    import pcc_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;

    // Q16.16 landmarks and word extremes
    localparam logic [DATA_W-1:0] Q_ONE  = 32'h0001_0000;
    localparam logic [DATA_W-1:0] W_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] W_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] W_ONES = 32'hFFFF_FFFF;

    // Register indexes past the end of the map; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Saturation bounds of the product terms and of the 48-bit integral
    localparam longint TERM_CAP = 64'sh1000_0000_0000_0000;
    localparam longint ACC_HI   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO   = 64'shFFFF_8000_0000_0000;

    typedef struct packed {
        logic [DATA_W-1:0]   ctrl;
        logic [STATUS_W-1:0] status;
    } ctrl_out_t;

    // One row of the directed plan: a register write or a reading to send
    typedef struct packed {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [DATA_W-1:0]    value;
        logic [DATA_W-1:0]    pv;
        logic [DATA_W-1:0]    dt;
        logic                 known;
        ctrl_out_t            want;
    } plan_step_t;

    typedef enum int {
        PH_TRACK,
        PH_WILD,
        PH_TWEAK
    } phase_kind_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [2*DATA_W-1:0]  s_axis_tdata;   // process_value, time_step
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [DATA_W-1:0]    m_axis_tdata;   // control_value
    logic [STATUS_W-1:0]  m_axis_tuser;   // clamp_status
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    // Predictor copy of the configuration and the loop state
    longint sp, kp, ki, kd, out_hi, out_lo;
    longint integ, prev_err;

    ctrl_out_t  awaited_outputs[$];
    plan_step_t plan_steps[$];
    int         fail_count = 0;
    int         items_sent = 0;
    logic       calm_tail  = 1'b0;

    pid_controller_clamped #(.FRAC_BITS(FRAC)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Floor-shifted product, clipped at magnitude 2^60 like every product term
    function automatic longint scaled_product(longint a, longint b);
        logic signed [127:0] wa, wb, prod;
        wa   = a;
        wb   = b;
        prod = (wa * wb) >>> FRAC;
        if (prod > TERM_CAP)
            prod = TERM_CAP;
        else if (prod < -TERM_CAP)
            prod = -TERM_CAP;
        return prod[63:0];
    endfunction

    // Advance the loop state by one reading and return the clamped output
    function automatic ctrl_out_t compute_control(logic [DATA_W-1:0] pv,
                                                  logic [DATA_W-1:0] dt);
        longint    err, dts, p_term, acc, num, quot, d_term, total;
        ctrl_out_t r;
        dts    = {32'd0, dt};
        err    = sp - longint'($signed(pv));
        p_term = scaled_product(err, kp);

        // Integral: saturate the accumulator to its 48-bit range
        acc = integ + scaled_product(scaled_product(err, ki), dts);
        if (acc > ACC_HI)
            acc = ACC_HI;
        if (acc < ACC_LO)
            acc = ACC_LO;
        integ = acc;

        // Derivative: slope of the error, zero step counts as the smallest step
        num      = (err - prev_err) <<< FRAC;
        quot     = num / ((dts == 0) ? 64'sd1 : dts);
        d_term   = scaled_product(quot, kd);
        prev_err = err;

        // High clamp first, low clamp second, so inverted limits end low
        total    = p_term + acc + d_term;
        r.status = ST_WITHIN;
        if (total > out_hi)
        begin
            total    = out_hi;
            r.status = ST_HIGH;
        end
        if (total < out_lo)
        begin
            total    = out_lo;
            r.status = ST_LOW;
        end
        r.ctrl = total[DATA_W-1:0];
        return r;
    endfunction

    task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        case (idx)
            CFG_SETPOINT:
            begin
                sp       = $signed(value);
                integ    = 0;
                prev_err = 0;
            end
            CFG_GAIN_P:  kp     = $signed(value);
            CFG_GAIN_I:  ki     = $signed(value);
            CFG_GAIN_D:  kd     = $signed(value);
            CFG_OUT_MAX: out_hi = $signed(value);
            CFG_OUT_MIN: out_lo = $signed(value);
            default:     ;
        endcase
    endtask

    // Drop tvalid and hold it low for the given number of cycles
    task automatic pause_input(int cycles);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Let every outstanding item come back so the block is idle
    task automatic settle();
        pause_input(1);
        while (awaited_outputs.size() != 0)
            @(posedge clk);
    endtask

    // One write on the config port; the predictor takes it at the same time
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        apply_register(idx, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Present one reading, wait for the handshake, then queue what must come back.
    // tvalid stays high; the next call or pause_input decides what follows.
    task automatic send_reading(logic [DATA_W-1:0] pv, logic [DATA_W-1:0] dt,
                                logic known, ctrl_out_t want);
        ctrl_out_t r;
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {dt, pv};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = compute_control(pv, dt);
        if (known)
            r = want;
        awaited_outputs.push_back(r);
        items_sent++;
    endtask

    task automatic add_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        plan_step_t s;
        s          = '0;
        s.is_write = 1'b1;
        s.reg_idx  = idx;
        s.value    = value;
        plan_steps.push_back(s);
    endtask

    task automatic add_reading(logic [DATA_W-1:0] pv, logic [DATA_W-1:0] dt);
        plan_step_t s;
        s    = '0;
        s.pv = pv;
        s.dt = dt;
        plan_steps.push_back(s);
    endtask

    task automatic add_reading_known(logic [DATA_W-1:0] pv, logic [DATA_W-1:0] dt,
                                     logic [DATA_W-1:0] ctrl, logic [STATUS_W-1:0] st);
        plan_step_t s;
        s             = '0;
        s.pv          = pv;
        s.dt          = dt;
        s.known       = 1'b1;
        s.want.ctrl   = ctrl;
        s.want.status = st;
        plan_steps.push_back(s);
    endtask

    // Signed value spread evenly over [-span, span]
    function automatic logic [DATA_W-1:0] near_zero(int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // Extremes, zero, small values and raw words in a rough mix
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return W_MAX;
            1:       return W_MIN;
            2:       return '0;
            3, 4:    return near_zero(8 * Q_ONE);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_step();
        logic [DATA_W-1:0] dt;
        dt = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(1, 4 * Q_ONE);
        return (dt == 0) ? 32'd1 : dt;
    endfunction

    // Load a register setting that suits the kind of phase
    task automatic setup_phase(phase_kind_t kind);
        int unsigned lim;
        case (kind)
            PH_TRACK:
            begin
                lim = $urandom_range(Q_ONE, 200 * Q_ONE);
                write_register(CFG_SETPOINT, near_zero(100 * Q_ONE));
                write_register(CFG_GAIN_P, near_zero(4 * Q_ONE));
                write_register(CFG_GAIN_I, near_zero(4 * Q_ONE));
                write_register(CFG_GAIN_D, near_zero(Q_ONE));
                write_register(CFG_OUT_MAX, ($urandom_range(0, 4) == 0) ? W_MAX : lim);
                write_register(CFG_OUT_MIN, ($urandom_range(0, 4) == 0) ? W_MIN : -lim);
            end
            PH_WILD:
            begin
                // keep the integral running across phases now and then
                if ($urandom_range(0, 1) != 0)
                    write_register(CFG_SETPOINT, pick_word());
                write_register(CFG_GAIN_P, pick_word());
                write_register(CFG_GAIN_I, pick_word());
                write_register(CFG_GAIN_D, pick_word());
                write_register(CFG_OUT_MAX, pick_word());
                write_register(CFG_OUT_MIN, pick_word());
            end
            default:
            begin
                repeat ($urandom_range(1, 3))
                    write_register(CFG_IDX_W'($urandom_range(0, 7)), pick_word());
            end
        endcase
    endtask

    // Idle the input for one short burst
    task automatic input_gap();
        pause_input($urandom_range(1, 12));
    endtask

    task automatic run_phase(phase_kind_t kind, int count, logic gappy);
        logic [DATA_W-1:0] pv, dt;
        settle();
        setup_phase(kind);
        repeat (count)
        begin
            if (kind == PH_TRACK && $urandom_range(0, 9) != 0)
            begin
                // hover around the setpoint with realistic sample intervals
                pv = sp[DATA_W-1:0] + near_zero(20 * Q_ONE);
                dt = $urandom_range(1, Q_ONE);
            end
            else
            begin
                pv = ($urandom_range(0, 1) != 0) ? $urandom : pick_word();
                dt = pick_step();
            end
            send_reading(pv, dt, 1'b0, '0);
            if (gappy && !calm_tail && $urandom_range(0, 3) == 0)
                input_gap();
        end
    endtask

    // Result checker: compare each accepted item with the oldest prediction
    task automatic report_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            $error("%s: expected %h, got %h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        ctrl_out_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_outputs.size() == 0)
            begin
                fail_count++;
                $error("result item with no prediction waiting: %h/%h",
                       m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                w = awaited_outputs.pop_front();
                report_field("control_value", w.ctrl, m_axis_tdata);
                report_field("clamp_status", {30'd0, w.status}, {30'd0, m_axis_tuser});
            end
        end
    end

    // Output back-pressure: random ready/stall bursts, long open stretches,
    // and no stalls at all once the tail of the run starts
    initial
    begin
        int   run;
        logic lvl;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (calm_tail || $urandom_range(0, 9) == 0)
            begin
                run = calm_tail ? 1 : $urandom_range(50, 200);
                lvl = 1'b1;
            end
            else
            begin
                run = $urandom_range(1, 12);
                lvl = 1'($urandom_range(0, 1));
            end
            repeat (run)
            begin
                @(negedge clk);
                m_axis_tready = lvl;
            end
        end
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        phase_kind_t kind;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_SETPOINT;
        cfg_data      = '0;

        // Predictor starts from the register reset values
        sp       = SETPOINT_RST;
        kp       = GAIN_P_RST;
        ki       = GAIN_I_RST;
        kd       = GAIN_D_RST;
        out_hi   = OUT_MAX_RST;
        out_lo   = OUT_MIN_RST;
        integ    = 0;
        prev_err = 0;

        // Directed plan. Reset setting: zero error gives zero output, a large
        // positive error clamps high, a large negative error clamps low.
        add_reading_known('0, Q_ONE, '0, ST_WITHIN);
        add_reading_known(W_MIN, Q_ONE, OUT_MAX_RST, ST_HIGH);
        add_reading_known(W_MAX, Q_ONE, OUT_MIN_RST, ST_LOW);
        add_reading('0, '0);                       // zero time step
        // Derivative on, limits opened to the word extremes
        add_write(CFG_GAIN_D, Q_ONE);
        add_write(CFG_OUT_MAX, W_MAX);
        add_write(CFG_OUT_MIN, W_MIN);
        add_reading(Q_ONE, '0);                    // zero step with a live derivative
        add_reading(32'hFFFF_0000, 32'd1);
        add_reading(32'h1234_5678, W_ONES);
        // Largest positive gains and setpoint: the integral and derivative products can hit their cap
        add_write(CFG_SETPOINT, W_MAX);
        add_write(CFG_GAIN_P, W_MAX);
        add_write(CFG_GAIN_I, W_MAX);
        add_write(CFG_GAIN_D, W_MAX);
        add_reading(W_MIN, 32'd1);
        add_reading(W_MIN, W_ONES);
        add_reading(W_MAX, W_ONES);
        // Most negative gains and setpoint
        add_write(CFG_SETPOINT, W_MIN);
        add_write(CFG_GAIN_P, W_MIN);
        add_write(CFG_GAIN_I, W_MIN);
        add_write(CFG_GAIN_D, W_MIN);
        add_reading(W_MAX, 32'd1);
        add_reading(W_MIN, W_ONES);
        add_reading('0, 32'd1);
        // Inverted limits: always out_min with a low clamp; spare indexes must
        // not disturb that
        add_write(CFG_OUT_MAX, 32'hFFFF_0000);
        add_write(CFG_OUT_MIN, Q_ONE);
        add_write(CFG_SPARE_LO, W_MIN);
        add_write(CFG_SPARE_HI, W_MAX);
        add_reading_known('0, Q_ONE, Q_ONE, ST_LOW);
        add_reading_known(W_MIN, 32'd1, Q_ONE, ST_LOW);
        add_reading(W_MAX, W_ONES);
        // Ordinary loop around a setpoint of 5.0
        add_write(CFG_OUT_MAX, 32'h0064_0000);
        add_write(CFG_OUT_MIN, 32'hFF9C_0000);
        add_write(CFG_GAIN_P, Q_ONE);
        add_write(CFG_GAIN_I, 32'h0000_8000);
        add_write(CFG_GAIN_D, 32'h0000_4000);
        add_write(CFG_SETPOINT, 32'h0005_0000);
        add_reading('0, 32'h0000_4000);
        add_reading(32'h0002_0000, 32'h0000_4000);
        add_reading(32'h0004_0000, 32'h0000_4000);
        add_reading(32'h0006_0000, 32'h0000_4000);

        // Hold reset, then release it on a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan_steps[i])
        begin
            if (plan_steps[i].is_write)
            begin
                settle();
                write_register(plan_steps[i].reg_idx, plan_steps[i].value);
            end
            else
            begin
                send_reading(plan_steps[i].pv, plan_steps[i].dt,
                             plan_steps[i].known, plan_steps[i].want);
            end
        end

        // Random phases, tracking most often
        while (items_sent < 1050)
        begin
            case ($urandom_range(0, 3))
                0, 1:    kind = PH_TRACK;
                2:       kind = PH_WILD;
                default: kind = PH_TWEAK;
            endcase
            run_phase(kind, $urandom_range(80, 120), $urandom_range(0, 3) != 0);
        end

        // Tail with no idling on either side
        calm_tail = 1'b1;
        run_phase(PH_TRACK, 150, 1'b0);

        settle();
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
